FILE: rtl/core/pdok_pkg.sv
// ----------------------------------------------------------------------------
// pdok_pkg
// Types and constants shared by the packed DNA overlap key extractor.
// ----------------------------------------------------------------------------
package pdok_pkg;

  localparam int KEY_W       = 62;
  localparam int LEN_W       = 5;
  localparam int SEEN_W      = 6;
  localparam int MAX_OVERLAP = 31;
  localparam logic [LEN_W-1:0] LEN_RESET = 5'd30;

  localparam logic [5:0] CODE6 = 6'b111111;
  localparam logic [5:0] CODE4 = 6'b001111;
  localparam logic [5:0] CODE2 = 6'b000011;

  localparam logic [1:0] TAG_ONE = 2'b01;
  localparam logic [1:0] TAG_TWO = 2'b10;

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic [7:0] trimmed_byte;
    logic       trimmed_valid;
    key_t       prefix_key;
    key_t       suffix_key;
    logic       keys_valid;
    logic       too_short;
  } pdok_result_t;

endpackage

FILE: rtl/core/pdok_step.sv
// ----------------------------------------------------------------------------
// pdok_step
// Sequence state (prefix accumulator, suffix window, nucleotide count) and the
// update that turns one packed byte into one result.
// ----------------------------------------------------------------------------
module pdok_step import pdok_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  logic [7:0]       packed_byte,
  input  logic             last_byte,
  input  logic [LEN_W-1:0] overlap_len,
  output pdok_result_t     result
);

  key_t              prefix_acc_r, prefix_acc_nxt;
  key_t              suffix_win_r, suffix_win_nxt;
  logic [SEEN_W-1:0] seen_r, seen_nxt;
  logic              done_r, done_nxt;

  logic [LEN_W-1:0]  len;
  logic [1:0]        cnt;
  logic [5:0]        codes;
  logic [SEEN_W-1:0] need;
  logic [1:0]        surplus;
  key_t              len_mask;
  key_t              acc_step;
  key_t              win_step;

  always_comb begin
    len = (overlap_len > LEN_W'(MAX_OVERLAP)) ? LEN_W'(MAX_OVERLAP) : overlap_len;
    cnt = packed_byte[7:6];
    case (cnt)
      2'd0:    codes = '0;
      2'd1:    codes = packed_byte[5:0] & CODE2;
      2'd2:    codes = packed_byte[5:0] & CODE4;
      default: codes = packed_byte[5:0] & CODE6;
    endcase
    need     = ({1'b0, len} > seen_r) ? ({1'b0, len} - seen_r) : '0;
    // A length of zero leaves an empty mask; the full length leaves all bits.
    len_mask = ~({KEY_W{1'b1}} << {len, 1'b0});
    surplus  = cnt - need[1:0];
    win_step = ((suffix_win_r << {cnt, 1'b0}) | key_t'(codes)) & len_mask;
  end

  always_comb begin
    prefix_acc_nxt        = prefix_acc_r;
    seen_nxt              = seen_r;
    done_nxt              = done_r;
    acc_step              = '0;
    result                = '0;
    if (done_r) begin
      if (cnt != 2'd0) begin
        result.trimmed_byte  = packed_byte;
        result.trimmed_valid = 1'b1;
      end
    end else if ({4'd0, cnt} < need) begin
      prefix_acc_nxt = (prefix_acc_r << {cnt, 1'b0}) | key_t'(codes);
      seen_nxt       = seen_r + {4'd0, cnt};
    end else begin
      // The byte completes the prefix; any surplus nucleotides go downstream.
      acc_step       = (prefix_acc_r << {need[1:0], 1'b0}) |
                       key_t'(codes >> {surplus, 1'b0});
      prefix_acc_nxt = acc_step;
      seen_nxt       = {1'b0, len};
      done_nxt       = 1'b1;
      case (surplus)
        2'd1: begin
          result.trimmed_byte  = {TAG_ONE, packed_byte[5:0] & CODE2};
          result.trimmed_valid = 1'b1;
        end
        2'd2: begin
          result.trimmed_byte  = {TAG_TWO, packed_byte[5:0] & CODE4};
          result.trimmed_valid = 1'b1;
        end
        2'd3: begin
          result.trimmed_byte  = packed_byte;
          result.trimmed_valid = 1'b1;
        end
        default: ;
      endcase
    end
    suffix_win_nxt = win_step;
    if (last_byte) begin
      if (done_nxt) begin
        result.keys_valid = 1'b1;
        result.prefix_key = prefix_acc_nxt;
        result.suffix_key = win_step;
      end else begin
        result.too_short  = 1'b1;
      end
      prefix_acc_nxt = '0;
      suffix_win_nxt = '0;
      seen_nxt       = '0;
      done_nxt       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_acc_r <= '0;
      suffix_win_r <= '0;
      seen_r       <= '0;
      done_r       <= 1'b0;
    end else if (step_en) begin
      prefix_acc_r <= prefix_acc_nxt;
      suffix_win_r <= suffix_win_nxt;
      seen_r       <= seen_nxt;
      done_r       <= done_nxt;
    end
  end

endmodule

FILE: rtl/core/packed_dna_overlap_key_extract.sv
// Pipeline: each request is held in the stage-1 register and its result in the
// output register; a stalled output holds both registers.
// Throughput: one request per cycle while out_stall is low; the state update in
// pdok_step is the only loop, so nothing but out_stall limits the rate.
// Reset: synchronous, active low; clears the pipeline valids and the sequence
// state, and sets the overlap length to 30.
// ----------------------------------------------------------------------------
// packed_dna_overlap_key_extract
// Trims the first L nucleotides from a packed DNA stream and gives the
// first-L and last-L nucleotide keys (or a too-short flag) on the final byte of each sequence.
// ----------------------------------------------------------------------------
module packed_dna_overlap_key_extract import pdok_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_packed_byte,
  input  logic             in_last_byte,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_overlap_len,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_trimmed_byte,
  output logic             out_trimmed_valid,
  output logic [KEY_W-1:0] out_prefix_key,
  output logic [KEY_W-1:0] out_suffix_key,
  output logic             out_keys_valid,
  output logic             out_too_short
);

  logic [LEN_W-1:0] overlap_len_r;
  logic             s1_valid_r, s1_valid_nxt;
  logic [7:0]       s1_byte_r;
  logic             s1_last_r;
  logic             out_valid_r, out_valid_nxt;
  pdok_result_t     out_res_r;
  pdok_result_t     step_res;
  logic             out_free;
  logic             s1_adv;
  logic             in_acc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      overlap_len_r <= LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      overlap_len_r <= cfg_overlap_len;
    end
  end

  always_comb begin
    out_free      = !out_valid_r || !out_stall;
    s1_adv        = s1_valid_r && out_free;
    in_stall      = s1_valid_r && !out_free;
    in_acc        = in_valid && !in_stall;
    s1_valid_nxt  = in_acc || (s1_valid_r && !s1_adv);
    out_valid_nxt = s1_adv || (out_valid_r && !out_free);
  end

  pdok_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (s1_adv),
    .packed_byte (s1_byte_r),
    .last_byte   (s1_last_r),
    .overlap_len (overlap_len_r),
    .result      (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_packed_byte;
      s1_last_r <= in_last_byte;
    end
    if (s1_adv) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_trimmed_byte  = out_res_r.trimmed_byte;
  assign out_trimmed_valid = out_res_r.trimmed_valid;
  assign out_prefix_key    = out_res_r.prefix_key;
  assign out_suffix_key    = out_res_r.suffix_key;
  assign out_keys_valid    = out_res_r.keys_valid;
  assign out_too_short     = out_res_r.too_short;

endmodule

FILE: rtl/core/pdok_checker.sv
// ----------------------------------------------------------------------------
// pdok_checker
// Port-level checks on the result channel of the overlap key extractor.
// ----------------------------------------------------------------------------
module pdok_checker import pdok_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_stall,
  input logic [7:0]       out_trimmed_byte,
  input logic             out_trimmed_valid,
  input logic [KEY_W-1:0] out_prefix_key,
  input logic [KEY_W-1:0] out_suffix_key,
  input logic             out_keys_valid,
  input logic             out_too_short
);

  // A final byte either yields keys or flags a short sequence, never both.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_keys_valid && out_too_short))
    else $error("keys_valid and too_short both set");

  a_keys_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_keys_valid) |-> (out_prefix_key == '0 && out_suffix_key == '0))
    else $error("keys nonzero without keys_valid");

  a_trim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_trimmed_valid) |-> (out_trimmed_byte == 8'd0))
    else $error("trimmed byte nonzero without trimmed_valid");

  // A kept byte always carries at least one nucleotide.
  a_trim_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_trimmed_valid) |-> (out_trimmed_byte[7:6] != 2'd0))
    else $error("kept byte with zero nucleotide count");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_trimmed_byte) &&
                                  $stable(out_prefix_key)))
    else $error("stalled result changed");

endmodule

bind packed_dna_overlap_key_extract pdok_checker u_pdok_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_trimmed_byte  (out_trimmed_byte),
  .out_trimmed_valid (out_trimmed_valid),
  .out_prefix_key    (out_prefix_key),
  .out_suffix_key    (out_suffix_key),
  .out_keys_valid    (out_keys_valid),
  .out_too_short     (out_too_short)
);

FILE: tb/tb_packed_dna_overlap_key_extract.sv
// ----------------------------------------------------------------------------
// tb_packed_dna_overlap_key_extract
// Streams packed DNA bytes through the overlap key extractor under several
// overlap lengths and random handshake gaps. Every request is predicted in
// the bench, and each result is checked field by field against the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module tb_packed_dna_overlap_key_extract import pdok_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] KEY_MASK = (64'd1 << KEY_W) - 64'd1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASES = 9;
  localparam int PHASE_BYTES = 145;

  // Predicts the trimmed stream and the key pair for each accepted byte.
  class overlap_key_checker;
    logic [LEN_W-1:0] overlap_len;
    logic [63:0]      prefix_acc;
    logic [63:0]      suffix_window;
    int unsigned      seen_count;
    bit               prefix_done;
    pdok_result_t     pending_results[$];
    int               errors;
    int               requests;
    int               keys_seen;
    int               short_seen;
    int               bytes_kept;

    function new();
      overlap_len = LEN_RESET;
      errors = 0;
      requests = 0;
      keys_seen = 0;
      short_seen = 0;
      bytes_kept = 0;
      clear_sequence();
    endfunction

    function void clear_sequence();
      prefix_acc = '0;
      suffix_window = '0;
      seen_count = 0;
      prefix_done = 1'b0;
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      int unsigned  len;
      int unsigned  n;
      int unsigned  need;
      int unsigned  surplus;
      logic [63:0]  codes;
      logic [63:0]  window_mask;
      pdok_result_t r;
      len = overlap_len;
      n = b[7:6];
      codes = (n == 0) ? 64'd0 : (64'(b[5:0]) & ((64'd1 << (2 * n)) - 64'd1));
      r = '0;
      requests++;
      if (prefix_done) begin
        if (n != 0) begin
          r.trimmed_byte = b;
          r.trimmed_valid = 1'b1;
        end
      end else begin
        need = (len > seen_count) ? len - seen_count : 0;
        if (n < need) begin
          prefix_acc = ((prefix_acc << (2 * n)) | codes) & KEY_MASK;
          seen_count = seen_count + n;
        end else begin
          // This byte completes the cut; only its surplus nucleotides go on.
          surplus = n - need;
          prefix_acc = ((prefix_acc << (2 * need)) | (codes >> (2 * surplus))) & KEY_MASK;
          seen_count = len;
          prefix_done = 1'b1;
          case (surplus)
            1: r.trimmed_byte = {TAG_ONE, b[5:0] & CODE2};
            2: r.trimmed_byte = {TAG_TWO, b[5:0] & CODE4};
            3: r.trimmed_byte = b;
            default: r.trimmed_byte = 8'h00;
          endcase
          r.trimmed_valid = (surplus != 0);
        end
      end
      window_mask = (len == 0) ? 64'd0 : (((64'd1 << (2 * len)) - 64'd1) & KEY_MASK);
      suffix_window = ((suffix_window << (2 * n)) | codes) & window_mask;
      if (last) begin
        if (prefix_done) begin
          r.keys_valid = 1'b1;
          r.prefix_key = prefix_acc[KEY_W-1:0];
          r.suffix_key = suffix_window[KEY_W-1:0];
          keys_seen++;
        end else begin
          r.too_short = 1'b1;
          short_seen++;
        end
        clear_sequence();
      end
      if (r.trimmed_valid) bytes_kept++;
      pending_results = {pending_results, r};
    endfunction

    function void match_result(pdok_result_t got);
      pdok_result_t want;
      if (pending_results.size() == 0) begin
        $error("result arrived with no request outstanding");
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.trimmed_byte !== want.trimmed_byte) begin
        $error("trimmed_byte: expected %0h, got %0h", want.trimmed_byte, got.trimmed_byte);
        errors++;
      end
      if (got.trimmed_valid !== want.trimmed_valid) begin
        $error("trimmed_valid: expected %0b, got %0b", want.trimmed_valid, got.trimmed_valid);
        errors++;
      end
      if (got.prefix_key !== want.prefix_key) begin
        $error("prefix_key: expected %0h, got %0h", want.prefix_key, got.prefix_key);
        errors++;
      end
      if (got.suffix_key !== want.suffix_key) begin
        $error("suffix_key: expected %0h, got %0h", want.suffix_key, got.suffix_key);
        errors++;
      end
      if (got.keys_valid !== want.keys_valid) begin
        $error("keys_valid: expected %0b, got %0b", want.keys_valid, got.keys_valid);
        errors++;
      end
      if (got.too_short !== want.too_short) begin
        $error("too_short: expected %0b, got %0b", want.too_short, got.too_short);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [7:0]       in_packed_byte;
  logic             in_last_byte;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_overlap_len;
  logic             out_valid;
  logic             out_stall;
  logic [7:0]       out_trimmed_byte;
  logic             out_trimmed_valid;
  logic [KEY_W-1:0] out_prefix_key;
  logic [KEY_W-1:0] out_suffix_key;
  logic             out_keys_valid;
  logic             out_too_short;
  pdok_result_t     out_now;

  int                 send_idle_pct;
  int                 recv_idle_pct;
  int                 cycle_count;
  int                 lengths_used;
  overlap_key_checker board;

  packed_dna_overlap_key_extract u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_packed_byte    (in_packed_byte),
    .in_last_byte      (in_last_byte),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_overlap_len   (cfg_overlap_len),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_trimmed_byte  (out_trimmed_byte),
    .out_trimmed_valid (out_trimmed_valid),
    .out_prefix_key    (out_prefix_key),
    .out_suffix_key    (out_suffix_key),
    .out_keys_valid    (out_keys_valid),
    .out_too_short     (out_too_short)
  );

  assign out_now = {out_trimmed_byte, out_trimmed_valid, out_prefix_key, out_suffix_key,
                    out_keys_valid, out_too_short};

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.match_result(out_now);
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_packed_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_byte(b, last);
  endtask

  // Lowers valid and waits until every predicted result has been seen.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_len(input logic [LEN_W-1:0] len);
    cfg_valid <= 1'b1;
    cfg_overlap_len <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.overlap_len = len;
    lengths_used++;
  endtask

  // Sends bytes until about target nucleotides have gone; an early end of
  // sequence is thrown in now and then to break the pattern.
  task automatic send_sequence(input int unsigned target, input bit close);
    int unsigned nt;
    int unsigned n;
    logic [7:0]  b;
    bit          last;
    nt = 0;
    do begin
      n = ($urandom_range(99) < 6) ? 0 : $urandom_range(1, 3);
      b = {2'(n), 6'($urandom)};
      nt = nt + n;
      last = close && (nt >= target || $urandom_range(99) < 2);
      send_byte(b, last);
    end while (!last && nt < target);
  endtask

  initial begin
    int unsigned len;
    int unsigned target;
    int          phase_start;
    bit          paused;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_packed_byte = '0;
    in_last_byte = 1'b0;
    cfg_valid = 1'b0;
    cfg_overlap_len = '0;
    out_stall = 1'b0;
    cycle_count = 0;
    lengths_used = 0;
    send_idle_pct = 35;
    recv_idle_pct = 84;
    paused = 1'b0;
    board = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: straddling cuts of each width, pass-through with unused
    // code bits, count-zero bytes and overlap lengths 1 and 31.
    write_len(5'd1);
    send_byte(8'hE4, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h3F, 1'b1);
    wait_drain();
    write_len(5'd2);
    send_byte(8'hC6, 1'b1);
    wait_drain();
    write_len(5'd1);
    send_byte(8'h41, 1'b1);
    send_byte(8'h00, 1'b1);
    wait_drain();
    write_len(5'd31);
    repeat (10) send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h40, 1'b1);
    wait_drain();
    // Shrinking the length mid-sequence leaves nothing more to cut: a full
    // byte then goes on whole, and a count-zero byte just closes the cut.
    write_len(5'd10);
    send_byte(8'hC0, 1'b0);
    send_byte(8'hFF, 1'b0);
    wait_drain();
    write_len(5'd4);
    send_byte(8'hDB, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hB5, 1'b1);
    wait_drain();
    write_len(5'd12);
    send_byte(8'hFF, 1'b0);
    wait_drain();
    write_len(5'd2);
    send_byte(8'h3F, 1'b0);
    send_byte(8'h55, 1'b1);
    wait_drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < 3) begin
        send_idle_pct = 35;
        recv_idle_pct = 84;
      end else if (phase < 6) begin
        send_idle_pct = 84;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (phase == 0 || phase == 5) len = 1;
      else if (phase == 1 || phase == 7) len = 31;
      else len = $urandom_range(1, 31);
      write_len(LEN_W'(len));
      phase_start = board.requests;
      while (board.requests - phase_start < PHASE_BYTES) begin
        if (phase == 4 && !paused && board.requests - phase_start > PHASE_BYTES / 2) begin
          wait_drain();
          paused = 1'b1;
        end
        if ($urandom_range(99) < 78) target = len + $urandom_range(0, len + 8);
        else target = $urandom_range(0, len - 1);
        send_sequence(target, 1'b1);
      end
      // Leave a sequence open so the next length takes over mid-sequence.
      if (phase % 3 == 1) send_sequence($urandom_range(1, 12), 1'b0);
      wait_drain();
    end

    $display("tb: %0d requests at %0d overlap length settings, %0d trimmed bytes kept",
             board.requests, lengths_used, board.bytes_kept);
    $display("tb: %0d sequences gave key pairs, %0d ended too short",
             board.keys_seen, board.short_seen);
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
